/* rtl/pts_pkg.sv */
// ---------------------------------------------------------------------------
// pts_pkg
// Shared types and constants for the four-level priority task scheduler.
// ---------------------------------------------------------------------------
package pts_pkg;

  // Fixed field widths
  localparam int NUM_LEVELS = 4;
  localparam int LVL_W      = 2;
  localparam int OP_W       = 2;
  localparam int TAG_W      = 16;
  localparam int DUR_W      = 16;
  localparam int CFG_W      = 7;
  localparam int WRK_W      = 8;
  localparam int ACT_W      = 8;
  localparam int QOUT_W     = 7;
  localparam int DONE_W     = 32;
  localparam int AVG_W      = 24;

  // Worker scale-up limits
  localparam int             WORKER_LIMIT = 64;
  localparam logic [CFG_W-1:0] ADDED_MAX  = 7'd127;
  localparam logic [ACT_W-1:0] ACT_MAX    = 8'd255;

  // Moving average: x/10 as (x * ceil(2^35/10)) >> 35, exact for 32-bit x
  localparam int              ACC_W        = 28;
  localparam int              PROD_W       = 60;
  localparam logic [31:0]     DIV10_MUL    = 32'hCCCC_CCCD;
  localparam int              DIV10_SHIFT  = 35;

  // Configuration port
  localparam int               CFG_AW          = 3;
  localparam int               CFG_DW          = 32;
  localparam logic             REG_MIN_WORKERS = 1'b0;
  localparam logic             REG_MAX_WORKERS = 1'b1;
  localparam logic [CFG_W-1:0] MIN_WORKERS_RST = 7'd2;
  localparam logic [CFG_W-1:0] MAX_WORKERS_RST = 7'd8;

  typedef enum logic [OP_W-1:0] {
    OP_SUBMIT   = 2'd0,
    OP_TAKE     = 2'd1,
    OP_COMPLETE = 2'd2
  } op_e_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_NO_ACTIVE = 2'd3
  } status_t;

  // One registered request beat
  typedef struct packed {
    logic             vld;
    logic [OP_W-1:0]  op;
    logic [LVL_W-1:0] lvl;
    logic [TAG_W-1:0] tag;
    logic [DUR_W-1:0] dur;
  } req_t;

  // Queue outcome of the request in flight
  typedef struct packed {
    logic push_ok;
    logic pop_ok;
  } qsts_t;

endpackage

/* rtl/pts_cfg.sv */
// ---------------------------------------------------------------------------
// pts_cfg
// APB-style register block holding the base and maximum worker counts.
// ---------------------------------------------------------------------------
module pts_cfg (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [pts_pkg::CFG_AW-1:0] paddr,
  input  logic [pts_pkg::CFG_DW-1:0] pwdata,
  output logic [pts_pkg::CFG_DW-1:0] prdata,
  output logic                       pready,
  output logic [pts_pkg::CFG_W-1:0]  min_workers,
  output logic [pts_pkg::CFG_W-1:0]  max_workers
);

  logic [pts_pkg::CFG_W-1:0] min_workers_r;
  logic [pts_pkg::CFG_W-1:0] max_workers_r;
  logic                      wr_en;

  // Registers sit on word boundaries; the word index selects
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  // Write registers on the access beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_workers_r <= pts_pkg::MIN_WORKERS_RST;
      max_workers_r <= pts_pkg::MAX_WORKERS_RST;
    end else if (wr_en) begin
      case (paddr[2])
        pts_pkg::REG_MIN_WORKERS: min_workers_r <= pwdata[pts_pkg::CFG_W-1:0];
        pts_pkg::REG_MAX_WORKERS: max_workers_r <= pwdata[pts_pkg::CFG_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    case (paddr[2])
      pts_pkg::REG_MIN_WORKERS: prdata = pts_pkg::CFG_DW'(min_workers_r);
      pts_pkg::REG_MAX_WORKERS: prdata = pts_pkg::CFG_DW'(max_workers_r);
      default:                  prdata = '0;
    endcase
  end

  assign min_workers = min_workers_r;
  assign max_workers = max_workers_r;

endmodule

/* rtl/pts_queue.sv */
// ---------------------------------------------------------------------------
// pts_queue
// Four FIFOs sharing one tag store, with strict-priority selection on take.
// ---------------------------------------------------------------------------
module pts_queue #(
  parameter int LEVEL_DEPTH = 16,
  parameter int QW          = 7
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  pts_pkg::req_t               req,
  output pts_pkg::qsts_t              qsts,
  output logic [QW-1:0]               q_next,
  output logic [QW-1:0]               q_count,
  output logic                        pop_ok_q,
  output logic [pts_pkg::LVL_W-1:0]   pop_lvl_q,
  output logic [pts_pkg::TAG_W-1:0]   pop_tag_q
);

  localparam int PW        = $clog2(LEVEL_DEPTH);
  localparam int CNTW      = $clog2(LEVEL_DEPTH + 1);
  localparam int MEM_DEPTH = pts_pkg::NUM_LEVELS * LEVEL_DEPTH;
  localparam int AW        = $clog2(MEM_DEPTH);

  logic [PW-1:0]   head_r  [pts_pkg::NUM_LEVELS];
  logic [PW-1:0]   tail_r  [pts_pkg::NUM_LEVELS];
  logic [CNTW-1:0] count_r [pts_pkg::NUM_LEVELS];
  logic [QW-1:0]   queue_r;
  logic            pop_ok_r;
  logic [pts_pkg::LVL_W-1:0] pop_lvl_r;
  logic [pts_pkg::TAG_W-1:0] rd_data_r;

  logic [pts_pkg::TAG_W-1:0] mem [MEM_DEPTH];

  logic [pts_pkg::NUM_LEVELS-1:0] nonempty;
  logic [pts_pkg::LVL_W-1:0]      sel_lvl;
  logic [pts_pkg::LVL_W-1:0]      idx;
  logic                           is_sub;
  logic                           is_take;
  logic                           push_ok;
  logic                           pop_ok;
  logic [PW-1:0]                  ptr;
  logic [PW-1:0]                  ptr_inc;
  logic [AW-1:0]                  addr;

  // Pick the highest non-empty level
  always_comb begin
    sel_lvl = '0;
    for (int l = 0; l < pts_pkg::NUM_LEVELS; l++) begin
      nonempty[l] = (count_r[l] != '0);
      if (nonempty[l]) begin
        sel_lvl = pts_pkg::LVL_W'(l);
      end
    end
  end

  assign is_sub  = req.vld && (req.op == pts_pkg::OP_SUBMIT);
  assign is_take = req.vld && (req.op == pts_pkg::OP_TAKE);
  assign idx     = is_take ? sel_lvl : req.lvl;

  assign push_ok = is_sub && (count_r[idx] < CNTW'(LEVEL_DEPTH));
  assign pop_ok  = is_take && (|nonempty);

  // Tail for a push, head for a take; wrap at the level depth
  assign ptr     = is_take ? head_r[idx] : tail_r[idx];
  assign ptr_inc = (ptr == PW'(LEVEL_DEPTH - 1)) ? '0 : ptr + 1'b1;
  assign addr    = AW'(idx) * AW'(LEVEL_DEPTH) + AW'(ptr);

  always_comb begin
    q_next = queue_r;
    if (push_ok) begin
      q_next = queue_r + 1'b1;
    end else if (pop_ok) begin
      q_next = queue_r - 1'b1;
    end
  end

  // Advance pointers and counts
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int l = 0; l < pts_pkg::NUM_LEVELS; l++) begin
        head_r[l]  <= '0;
        tail_r[l]  <= '0;
        count_r[l] <= '0;
      end
      queue_r  <= '0;
      pop_ok_r <= 1'b0;
    end else begin
      pop_ok_r <= pop_ok;
      queue_r  <= q_next;
      if (push_ok) begin
        tail_r[idx]  <= ptr_inc;
        count_r[idx] <= count_r[idx] + 1'b1;
      end else if (pop_ok) begin
        head_r[idx]  <= ptr_inc;
        count_r[idx] <= count_r[idx] - 1'b1;
      end
    end
  end

  // Tag store: one access per beat, read data registered
  always_ff @(posedge clk) begin
    if (push_ok) begin
      mem[addr] <= req.tag;
    end
    if (pop_ok) begin
      rd_data_r <= mem[addr];
    end
    pop_lvl_r <= sel_lvl;
  end

  assign qsts.push_ok = push_ok;
  assign qsts.pop_ok  = pop_ok;
  assign q_count      = queue_r;
  assign pop_ok_q     = pop_ok_r;
  assign pop_lvl_q    = pop_lvl_r;
  assign pop_tag_q    = rd_data_r;

endmodule

/* rtl/pts_stats.sv */
// ---------------------------------------------------------------------------
// pts_stats
// Worker scaling, active and done counters, high-water mark, moving average
// and result status.
// ---------------------------------------------------------------------------
module pts_stats #(
  parameter int QW = 7
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  pts_pkg::req_t                req,
  input  pts_pkg::qsts_t               qsts,
  input  logic [QW-1:0]                q_next,
  input  logic [pts_pkg::CFG_W-1:0]    min_workers,
  input  logic [pts_pkg::CFG_W-1:0]    max_workers,
  output pts_pkg::status_t             status,
  output logic                         scaled,
  output logic [pts_pkg::WRK_W-1:0]    worker_count,
  output logic [pts_pkg::ACT_W-1:0]    active_count,
  output logic [QW-1:0]                peak,
  output logic [pts_pkg::DONE_W-1:0]   done_count,
  output logic [pts_pkg::AVG_W-1:0]    avg_time
);

  localparam int CMPW = (QW > pts_pkg::WRK_W + 1) ? QW : pts_pkg::WRK_W + 1;

  logic [pts_pkg::CFG_W-1:0]  added_r,  added_nxt;
  logic [pts_pkg::ACT_W-1:0]  active_r, active_nxt;
  logic [QW-1:0]              peak_r,   peak_nxt;
  logic [pts_pkg::DONE_W-1:0] done_r,   done_nxt;
  logic [pts_pkg::AVG_W-1:0]  avg_r,    avg_nxt;
  pts_pkg::status_t           status_r, status_nxt;
  logic                       scaled_r, scaled_nxt;

  logic [pts_pkg::WRK_W-1:0]  workers;
  logic [pts_pkg::ACC_W-1:0]  acc;
  logic [pts_pkg::PROD_W-1:0] prod;
  logic                       is_done;
  logic                       can_scale;

  assign workers = pts_pkg::WRK_W'(min_workers) + pts_pkg::WRK_W'(added_r);

  // avg*9 + dur*256, then divide by ten through the reciprocal
  assign acc  = (pts_pkg::ACC_W'(avg_r) << 3) + pts_pkg::ACC_W'(avg_r)
              + (pts_pkg::ACC_W'(req.dur) << 8);
  assign prod = pts_pkg::PROD_W'(acc) * pts_pkg::PROD_W'(pts_pkg::DIV10_MUL);

  assign is_done = req.vld && (req.op == pts_pkg::OP_COMPLETE) && (active_r != '0);

  assign can_scale = (CMPW'(q_next) > CMPW'({workers, 1'b0}))
                  && (workers < pts_pkg::WRK_W'(max_workers))
                  && (added_r < pts_pkg::ADDED_MAX)
                  && (9'(added_r) < 9'(pts_pkg::WORKER_LIMIT));

  // Next state and status for the beat in flight
  always_comb begin
    added_nxt  = added_r;
    active_nxt = active_r;
    peak_nxt   = peak_r;
    done_nxt   = done_r;
    avg_nxt    = avg_r;
    scaled_nxt = 1'b0;
    status_nxt = pts_pkg::ST_OK;

    if (qsts.push_ok) begin
      if (q_next > peak_r) begin
        peak_nxt = q_next;
      end
      if (can_scale) begin
        added_nxt  = added_r + 1'b1;
        scaled_nxt = 1'b1;
      end
    end

    if (qsts.pop_ok && (active_r != pts_pkg::ACT_MAX)) begin
      active_nxt = active_r + 1'b1;
    end

    if (is_done) begin
      active_nxt = active_r - 1'b1;
      done_nxt   = done_r + 1'b1;
      avg_nxt    = prod[pts_pkg::DIV10_SHIFT +: pts_pkg::AVG_W];
    end

    case (req.op)
      pts_pkg::OP_SUBMIT:
        if (!qsts.push_ok) status_nxt = pts_pkg::ST_FULL;
      pts_pkg::OP_TAKE:
        if (!qsts.pop_ok) status_nxt = pts_pkg::ST_EMPTY;
      pts_pkg::OP_COMPLETE:
        if (active_r == '0) status_nxt = pts_pkg::ST_NO_ACTIVE;
      default: status_nxt = pts_pkg::ST_OK;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      added_r  <= '0;
      active_r <= '0;
      peak_r   <= '0;
      done_r   <= '0;
      avg_r    <= '0;
      scaled_r <= 1'b0;
      status_r <= pts_pkg::ST_OK;
    end else if (req.vld) begin
      added_r  <= added_nxt;
      active_r <= active_nxt;
      peak_r   <= peak_nxt;
      done_r   <= done_nxt;
      avg_r    <= avg_nxt;
      scaled_r <= scaled_nxt;
      status_r <= status_nxt;
    end
  end

  assign status       = status_r;
  assign scaled       = scaled_r;
  assign worker_count = workers;
  assign active_count = active_r;
  assign peak         = peak_r;
  assign done_count   = done_r;
  assign avg_time     = avg_r;

endmodule

/* rtl/priority_task_scheduler.sv */
// ---------------------------------------------------------------------------
// priority_task_scheduler
// Four-level strict-priority task scheduler with per-level FIFOs, worker
// scale-up, activity counters and a moving average of task time.
//
//   channel   handshake                  payload
//   -------   ------------------------   ---------------------------------
//   request   start, busy (beat when     in_operation, in_priority_req,
//             start high, busy low)      in_task_tag, in_duration_ms
//   result    out_valid (one cycle)      out_op_status .. out_avg_time
//   config    psel, penable, pwrite,     paddr, pwdata, prdata
//             pready (always high)
//
// One request beat per cycle; busy stays low. Each beat gives one result,
// registered first in the request register and then in the update stage
// that also registers the tag store read.
// Reset (synchronous, rst_n low) empties all levels and clears counters;
// the tag store itself is not cleared and takes no clearing pass.
// The result is shown for one cycle only; the receiver cannot stall it.
// ---------------------------------------------------------------------------
module priority_task_scheduler #(
  parameter int LEVEL_DEPTH = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // request
  input  logic                        start,
  output logic                        busy,
  input  logic [pts_pkg::OP_W-1:0]    in_operation,
  input  logic [pts_pkg::LVL_W-1:0]   in_priority_req,
  input  logic [pts_pkg::TAG_W-1:0]   in_task_tag,
  input  logic [pts_pkg::DUR_W-1:0]   in_duration_ms,
  // result
  output logic                        out_valid,
  output logic [1:0]                  out_op_status,
  output logic [pts_pkg::TAG_W-1:0]   out_tag,
  output logic [pts_pkg::LVL_W-1:0]   out_priority,
  output logic                        out_scaled_up,
  output logic [pts_pkg::WRK_W-1:0]   out_worker_count,
  output logic [pts_pkg::ACT_W-1:0]   out_active_count,
  output logic [pts_pkg::QOUT_W-1:0]  out_queue_count,
  output logic [pts_pkg::QOUT_W-1:0]  out_high_water,
  output logic [pts_pkg::DONE_W-1:0]  out_tasks_done,
  output logic [pts_pkg::AVG_W-1:0]   out_avg_time,
  // configuration
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [pts_pkg::CFG_AW-1:0]  paddr,
  input  logic [pts_pkg::CFG_DW-1:0]  pwdata,
  output logic [pts_pkg::CFG_DW-1:0]  prdata,
  output logic                        pready
);

  localparam int QW = $clog2(pts_pkg::NUM_LEVELS * LEVEL_DEPTH + 1);

  pts_pkg::req_t             req_r, req_nxt;
  logic                      out_valid_r;
  pts_pkg::qsts_t            qsts;
  logic [QW-1:0]             q_next;
  logic [QW-1:0]             q_count;
  logic [QW-1:0]             peak;
  logic                      pop_ok_q;
  logic [pts_pkg::LVL_W-1:0] pop_lvl_q;
  logic [pts_pkg::TAG_W-1:0] pop_tag_q;
  logic [pts_pkg::CFG_W-1:0] min_workers;
  logic [pts_pkg::CFG_W-1:0] max_workers;
  pts_pkg::status_t          status;
  logic                      accept;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_comb begin
    req_nxt.vld = accept;
    req_nxt.op  = in_operation;
    req_nxt.lvl = in_priority_req;
    req_nxt.tag = in_task_tag;
    req_nxt.dur = in_duration_ms;
  end

  // Capture the request beat; flag the result one stage later
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      req_r       <= req_nxt;
      out_valid_r <= req_r.vld;
    end
  end

  pts_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .min_workers (min_workers),
    .max_workers (max_workers)
  );

  pts_queue #(
    .LEVEL_DEPTH (LEVEL_DEPTH),
    .QW          (QW)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (req_r),
    .qsts      (qsts),
    .q_next    (q_next),
    .q_count   (q_count),
    .pop_ok_q  (pop_ok_q),
    .pop_lvl_q (pop_lvl_q),
    .pop_tag_q (pop_tag_q)
  );

  pts_stats #(
    .QW (QW)
  ) u_stats (
    .clk          (clk),
    .rst_n        (rst_n),
    .req          (req_r),
    .qsts         (qsts),
    .q_next       (q_next),
    .min_workers  (min_workers),
    .max_workers  (max_workers),
    .status       (status),
    .scaled       (out_scaled_up),
    .worker_count (out_worker_count),
    .active_count (out_active_count),
    .peak         (peak),
    .done_count   (out_tasks_done),
    .avg_time     (out_avg_time)
  );

  // Drive the result beat; tag and level only for a successful take
  assign out_valid       = out_valid_r;
  assign out_op_status   = status;
  assign out_tag         = pop_ok_q ? pop_tag_q : '0;
  assign out_priority    = pop_ok_q ? pop_lvl_q : '0;
  assign out_queue_count = pts_pkg::QOUT_W'(q_count);
  assign out_high_water  = pts_pkg::QOUT_W'(peak);

  // Every accepted beat yields a result after the request and update stages
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> ##1 out_valid)
    else $error("result missing two cycles after request");

  // No result without an accepted request before it
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(accept, 2))
    else $error("result without request");

  // A scale-up raises the worker count by exactly one
  a_scale_step: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_scaled_up) |->
      (out_worker_count == $past(out_worker_count) + 8'd1))
    else $error("scale-up did not add one worker");

  // Queue total never exceeds the combined level depth
  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_count <= QW'(pts_pkg::NUM_LEVELS * LEVEL_DEPTH))
    else $error("queue count beyond capacity");

endmodule

/* test/tb_top.sv */
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the four-level priority task scheduler. Request
// beats are driven with random gaps, each accepted beat is run through an
// in-bench scheduler model, and every strobed result is compared field by
// field with the oldest expected result. Worker limits are reprogrammed
// over the APB port between phases, and each write is read back.
// ---------------------------------------------------------------------------
module tb_top;

  localparam int LEVEL_DEPTH  = 16;
  localparam int CLK_HALF     = 2;
  localparam int RESET_CYCLES = 10;
  localparam int MAX_GAP      = 19;
  localparam int SETTLE       = 8;
  localparam int MAX_PRINTS   = 30;
  localparam int TIMEOUT      = 3_000_000;

  localparam logic [pts_pkg::OP_W-1:0]   OP_UNUSED     = 2'd3;
  localparam logic [pts_pkg::CFG_AW-1:0] ADDR_MIN_WORK = {pts_pkg::REG_MIN_WORKERS, 2'b00};
  localparam logic [pts_pkg::CFG_AW-1:0] ADDR_MAX_WORK = {pts_pkg::REG_MAX_WORKERS, 2'b00};

  typedef struct packed {
    pts_pkg::status_t            status;
    logic [pts_pkg::TAG_W-1:0]   tag;
    logic [pts_pkg::LVL_W-1:0]   prio;
    logic                        scaled;
    logic [pts_pkg::WRK_W-1:0]   workers;
    logic [pts_pkg::ACT_W-1:0]   active;
    logic [pts_pkg::QOUT_W-1:0]  queued;
    logic [pts_pkg::QOUT_W-1:0]  peak;
    logic [pts_pkg::DONE_W-1:0]  done;
    logic [pts_pkg::AVG_W-1:0]   avg;
  } sched_result_t;

  logic                          clk;
  logic                          rst_n;
  logic                          start;
  logic                          busy;
  logic [pts_pkg::OP_W-1:0]      in_operation;
  logic [pts_pkg::LVL_W-1:0]     in_priority_req;
  logic [pts_pkg::TAG_W-1:0]     in_task_tag;
  logic [pts_pkg::DUR_W-1:0]     in_duration_ms;
  logic                          out_valid;
  logic [1:0]                    out_op_status;
  logic [pts_pkg::TAG_W-1:0]     out_tag;
  logic [pts_pkg::LVL_W-1:0]     out_priority;
  logic                          out_scaled_up;
  logic [pts_pkg::WRK_W-1:0]     out_worker_count;
  logic [pts_pkg::ACT_W-1:0]     out_active_count;
  logic [pts_pkg::QOUT_W-1:0]    out_queue_count;
  logic [pts_pkg::QOUT_W-1:0]    out_high_water;
  logic [pts_pkg::DONE_W-1:0]    out_tasks_done;
  logic [pts_pkg::AVG_W-1:0]     out_avg_time;
  logic                          psel;
  logic                          penable;
  logic                          pwrite;
  logic [pts_pkg::CFG_AW-1:0]    paddr;
  logic [pts_pkg::CFG_DW-1:0]    pwdata;
  logic [pts_pkg::CFG_DW-1:0]    prdata;
  logic                          pready;

  // Scheduler model state
  logic [pts_pkg::TAG_W-1:0] sched_store [0:pts_pkg::NUM_LEVELS*LEVEL_DEPTH-1];
  int unsigned      sched_head [pts_pkg::NUM_LEVELS];
  int unsigned      sched_tail [pts_pkg::NUM_LEVELS];
  int unsigned      sched_cnt  [pts_pkg::NUM_LEVELS];
  int unsigned      sched_added;
  int unsigned      sched_active;
  int unsigned      sched_peak;
  logic [31:0]      sched_done;
  logic [31:0]      sched_avg;
  int unsigned      sched_min_workers;
  int unsigned      sched_max_workers;

  sched_result_t pending_results[$];

  int  errors;
  int  prints;
  int  n_submit, n_take, n_complete, n_unused;
  int  n_full, n_empty, n_no_active, n_scaled;
  int  n_checked;
  bit  burst_mode;

  priority_task_scheduler #(.LEVEL_DEPTH(LEVEL_DEPTH)) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_operation     (in_operation),
    .in_priority_req  (in_priority_req),
    .in_task_tag      (in_task_tag),
    .in_duration_ms   (in_duration_ms),
    .out_valid        (out_valid),
    .out_op_status    (out_op_status),
    .out_tag          (out_tag),
    .out_priority     (out_priority),
    .out_scaled_up    (out_scaled_up),
    .out_worker_count (out_worker_count),
    .out_active_count (out_active_count),
    .out_queue_count  (out_queue_count),
    .out_high_water   (out_high_water),
    .out_tasks_done   (out_tasks_done),
    .out_avg_time     (out_avg_time),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  // Free-running clock
  always #CLK_HALF clk = ~clk;

  // Print one mismatch line (capped) and count it
  task automatic report_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want);
    errors++;
    if (prints < MAX_PRINTS) begin
      $display("[%0t] mismatch: %s got 0x%0h expected 0x%0h", $time, what, got, want);
      prints++;
    end
  endtask

  function automatic int unsigned total_queued();
    int unsigned sum;
    sum = 0;
    for (int l = 0; l < pts_pkg::NUM_LEVELS; l++) sum += sched_cnt[l];
    return sum;
  endfunction

  // Advance the scheduler model by one request and return its result
  function automatic sched_result_t schedule_step(input logic [pts_pkg::OP_W-1:0] op,
                                                  input logic [pts_pkg::LVL_W-1:0] lvl,
                                                  input logic [pts_pkg::TAG_W-1:0] tag,
                                                  input logic [pts_pkg::DUR_W-1:0] dur);
    sched_result_t res;
    int unsigned   q;
    int unsigned   workers;
    int unsigned   slot;
    logic [63:0]   acc;
    bit            found;
    res = '0;
    res.status = pts_pkg::ST_OK;
    found = 0;
    case (op)
      pts_pkg::OP_SUBMIT: begin
        if (sched_cnt[lvl] >= LEVEL_DEPTH) begin
          res.status = pts_pkg::ST_FULL;
        end else begin
          slot = lvl * LEVEL_DEPTH + sched_tail[lvl];
          sched_store[slot] = tag;
          sched_tail[lvl] = (sched_tail[lvl] + 1) % LEVEL_DEPTH;
          sched_cnt[lvl]++;
          q = total_queued();
          if (q > sched_peak) sched_peak = q;
          workers = sched_min_workers + sched_added;
          if (q > workers * 2 && workers < sched_max_workers &&
              sched_added < pts_pkg::WORKER_LIMIT && sched_added < pts_pkg::ADDED_MAX) begin
            sched_added++;
            res.scaled = 1'b1;
          end
        end
      end
      pts_pkg::OP_TAKE: begin
        res.status = pts_pkg::ST_EMPTY;
        // Highest non-empty level wins, oldest tag first
        for (int l = pts_pkg::NUM_LEVELS - 1; l >= 0; l--) begin
          if (!found && sched_cnt[l] != 0) begin
            found = 1;
            slot = l * LEVEL_DEPTH + sched_head[l];
            res.tag = sched_store[slot];
            res.prio = l[pts_pkg::LVL_W-1:0];
            sched_head[l] = (sched_head[l] + 1) % LEVEL_DEPTH;
            sched_cnt[l]--;
            if (sched_active < pts_pkg::ACT_MAX) sched_active++;
            res.status = pts_pkg::ST_OK;
          end
        end
      end
      pts_pkg::OP_COMPLETE: begin
        if (sched_active == 0) begin
          res.status = pts_pkg::ST_NO_ACTIVE;
        end else begin
          sched_active--;
          sched_done = sched_done + 1;
          acc = 64'(sched_avg) * 64'd9 + 64'(dur) * 64'd256;
          sched_avg = 32'((acc / 64'd10) & 64'hFF_FFFF);
        end
      end
      default: ;
    endcase
    workers = sched_min_workers + sched_added;
    res.workers = workers[pts_pkg::WRK_W-1:0];
    res.active  = sched_active[pts_pkg::ACT_W-1:0];
    res.queued  = pts_pkg::QOUT_W'(total_queued());
    res.peak    = sched_peak[pts_pkg::QOUT_W-1:0];
    res.done    = sched_done;
    res.avg     = sched_avg[pts_pkg::AVG_W-1:0];
    return res;
  endfunction

  // Send one request beat after a random gap; predict on acceptance
  task automatic send_request(input logic [pts_pkg::OP_W-1:0] op,
                              input logic [pts_pkg::LVL_W-1:0] lvl,
                              input logic [pts_pkg::TAG_W-1:0] tag,
                              input logic [pts_pkg::DUR_W-1:0] dur);
    int gap;
    sched_result_t res;
    @(negedge clk);
    gap = burst_mode ? 0 : $urandom_range(0, MAX_GAP);
    if ($urandom_range(0, 39) == 0) burst_mode = !burst_mode;
    if (gap != 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
    start           = 1'b1;
    in_operation    = op;
    in_priority_req = lvl;
    in_task_tag     = tag;
    in_duration_ms  = dur;
    @(posedge clk);
    while (busy) @(posedge clk);
    res = schedule_step(op, lvl, tag, dur);
    pending_results.push_back(res);
    case (op)
      pts_pkg::OP_SUBMIT:   n_submit++;
      pts_pkg::OP_TAKE:     n_take++;
      pts_pkg::OP_COMPLETE: n_complete++;
      default:              n_unused++;
    endcase
    case (res.status)
      pts_pkg::ST_FULL:      n_full++;
      pts_pkg::ST_EMPTY:     n_empty++;
      pts_pkg::ST_NO_ACTIVE: n_no_active++;
      default: ;
    endcase
    if (res.scaled) n_scaled++;
  endtask

  // Drop start and wait until every expected result is back, then settle
  task automatic drain_results();
    @(negedge clk);
    start = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // APB write: setup then access, written on the access edge
  task automatic cfg_write(input logic [pts_pkg::CFG_AW-1:0] addr,
                           input logic [pts_pkg::CFG_W-1:0] value);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = addr;
    pwdata  = pts_pkg::CFG_DW'(value);
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (addr == ADDR_MIN_WORK) sched_min_workers = 32'(value);
    else sched_max_workers = 32'(value);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  // APB read and compare against the expected register value
  task automatic cfg_read_check(input logic [pts_pkg::CFG_AW-1:0] addr,
                                input int unsigned want);
    logic [pts_pkg::CFG_DW-1:0] got;
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = addr;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    got = prdata;
    if (got[pts_pkg::CFG_W-1:0] !== want[pts_pkg::CFG_W-1:0])
      report_mismatch($sformatf("register read at 0x%0h", addr),
                      got[pts_pkg::CFG_W-1:0], want);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  task automatic set_worker_limits(input int unsigned min_w, input int unsigned max_w);
    drain_results();
    cfg_write(ADDR_MIN_WORK, min_w[pts_pkg::CFG_W-1:0]);
    cfg_write(ADDR_MAX_WORK, max_w[pts_pkg::CFG_W-1:0]);
    cfg_read_check(ADDR_MIN_WORK, min_w);
    cfg_read_check(ADDR_MAX_WORK, max_w);
  endtask

  // Reset values of the registers
  task automatic test_register_reset();
    cfg_read_check(ADDR_MIN_WORK, 32'(pts_pkg::MIN_WORKERS_RST));
    cfg_read_check(ADDR_MAX_WORK, 32'(pts_pkg::MAX_WORKERS_RST));
  endtask

  // Every operation and the simple corner cases with the reset limits
  task automatic test_directed_ops();
    send_request(pts_pkg::OP_TAKE, 2'd0, 16'h0000, 16'h0000);     // take from empty levels
    send_request(pts_pkg::OP_COMPLETE, 2'd3, 16'h0000, 16'hFFFF); // completion, none active
    send_request(OP_UNUSED, 2'd3, 16'hFFFF, 16'hFFFF);            // unused code is ignored
    send_request(pts_pkg::OP_SUBMIT, 2'd0, 16'h0000, 16'h0000);
    send_request(pts_pkg::OP_SUBMIT, 2'd1, 16'hFFFF, 16'hFFFF);
    send_request(pts_pkg::OP_SUBMIT, 2'd2, 16'h5A5A, 16'h0000);
    send_request(pts_pkg::OP_SUBMIT, 2'd3, 16'hA5A5, 16'h0000);
    send_request(pts_pkg::OP_SUBMIT, 2'd3, 16'h1234, 16'h0000);
    send_request(pts_pkg::OP_SUBMIT, 2'd1, 16'h8001, 16'h0000);
    repeat (7) send_request(pts_pkg::OP_TAKE, 2'd0, 16'h0000, 16'h0000);
    send_request(pts_pkg::OP_COMPLETE, 2'd0, 16'h0000, 16'h0000);
    send_request(pts_pkg::OP_COMPLETE, 2'd0, 16'h0000, 16'hFFFF);
    send_request(pts_pkg::OP_COMPLETE, 2'd0, 16'h0000, 16'h0001);
    send_request(pts_pkg::OP_COMPLETE, 2'd0, 16'h0000, 16'h8000);
    send_request(pts_pkg::OP_COMPLETE, 2'd0, 16'h0000, 16'h7FFF);
    send_request(pts_pkg::OP_COMPLETE, 2'd0, 16'h0000, 16'hFFFF);
    send_request(pts_pkg::OP_COMPLETE, 2'd0, 16'h0000, 16'hFFFF);
  endtask

  // Fill every level past full with wide limits so scale-up runs far
  task automatic test_full_levels_and_scale_up();
    set_worker_limits(1, 64);
    for (int l = 0; l < pts_pkg::NUM_LEVELS; l++)
      repeat (LEVEL_DEPTH + 1)
        send_request(pts_pkg::OP_SUBMIT, l[pts_pkg::LVL_W-1:0], 16'($urandom), 16'h0);
    repeat (pts_pkg::NUM_LEVELS * LEVEL_DEPTH + 1)
      send_request(pts_pkg::OP_TAKE, 2'd0, 16'h0, 16'h0);
    repeat (pts_pkg::NUM_LEVELS * LEVEL_DEPTH)
      send_request(pts_pkg::OP_COMPLETE, 2'd0, 16'h0, 16'($urandom));
  endtask

  // Push the active count into saturation, then retire all at full duration
  task automatic test_active_saturation();
    for (int i = 0; i < 260; i++) begin
      send_request(pts_pkg::OP_SUBMIT, 2'($urandom), 16'($urandom), 16'h0);
      send_request(pts_pkg::OP_TAKE, 2'($urandom), 16'($urandom), 16'h0);
    end
    repeat (256) send_request(pts_pkg::OP_COMPLETE, 2'd0, 16'h0, 16'hFFFF);
  endtask

  // Random traffic: mostly real scheduling work with some unused codes
  task automatic test_random_phase(input int items, input int submit_pct);
    int          pick;
    int          hot_level;
    logic [1:0]  op;
    logic [1:0]  lvl;
    logic [15:0] dur;
    hot_level = ($urandom_range(0, 1) == 1) ?
                int'($urandom_range(0, pts_pkg::NUM_LEVELS - 1)) : -1;
    for (int i = 0; i < items; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < submit_pct) op = pts_pkg::OP_SUBMIT;
      else if (pick < submit_pct + (100 - submit_pct) * 55 / 100) op = pts_pkg::OP_TAKE;
      else if (pick < 97) op = pts_pkg::OP_COMPLETE;
      else op = OP_UNUSED;
      lvl = 2'($urandom);
      if (hot_level >= 0 && $urandom_range(0, 1) == 1) lvl = hot_level[1:0];
      case ($urandom_range(0, 7))
        0:       dur = 16'h0000;
        1:       dur = 16'hFFFF;
        default: dur = 16'($urandom);
      endcase
      send_request(op, lvl, 16'($urandom), dur);
    end
  endtask

  // Compare each strobed result with the oldest expectation
  always @(posedge clk) begin
    sched_result_t want;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with none expected, status", out_op_status, 0);
      end else begin
        want = pending_results.pop_front();
        n_checked++;
        if (out_op_status !== want.status)
          report_mismatch("op_status", out_op_status, want.status);
        if (out_tag !== want.tag)
          report_mismatch("tag", out_tag, want.tag);
        if (out_priority !== want.prio)
          report_mismatch("priority", out_priority, want.prio);
        if (out_scaled_up !== want.scaled)
          report_mismatch("scaled_up", out_scaled_up, want.scaled);
        if (out_worker_count !== want.workers)
          report_mismatch("worker_count", out_worker_count, want.workers);
        if (out_active_count !== want.active)
          report_mismatch("active_count", out_active_count, want.active);
        if (out_queue_count !== want.queued)
          report_mismatch("queue_count", out_queue_count, want.queued);
        if (out_high_water !== want.peak)
          report_mismatch("high_water", out_high_water, want.peak);
        if (out_tasks_done !== want.done)
          report_mismatch("tasks_done", out_tasks_done, want.done);
        if (out_avg_time !== want.avg)
          report_mismatch("avg_time", out_avg_time, want.avg);
      end
    end
  end

  // Hard stop if the run hangs
  initial begin
    #(TIMEOUT);
    $display("timeout with %0d results outstanding", pending_results.size());
    $display("** priority_task_scheduler: FAILED **");
    $finish;
  end

  initial begin
    clk             = 1'b0;
    rst_n           = 1'b0;
    start           = 1'b0;
    in_operation    = pts_pkg::OP_SUBMIT;
    in_priority_req = '0;
    in_task_tag     = '0;
    in_duration_ms  = '0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    errors = 0; prints = 0; n_checked = 0;
    n_submit = 0; n_take = 0; n_complete = 0; n_unused = 0;
    n_full = 0; n_empty = 0; n_no_active = 0; n_scaled = 0;
    burst_mode = 1'b0;

    // Model state after reset
    for (int i = 0; i < pts_pkg::NUM_LEVELS * LEVEL_DEPTH; i++) sched_store[i] = '0;
    for (int l = 0; l < pts_pkg::NUM_LEVELS; l++) begin
      sched_head[l] = 0;
      sched_tail[l] = 0;
      sched_cnt[l]  = 0;
    end
    sched_added = 0; sched_active = 0; sched_peak = 0;
    sched_done = '0; sched_avg = '0;
    sched_min_workers = 32'(pts_pkg::MIN_WORKERS_RST);
    sched_max_workers = 32'(pts_pkg::MAX_WORKERS_RST);

    // Hold reset, release on a falling edge
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n = 1'b1;

    test_register_reset();
    test_directed_ops();
    test_full_levels_and_scale_up();
    test_active_saturation();
    set_worker_limits(1, 64);
    test_random_phase(200, 60);
    set_worker_limits(64, 1);
    test_random_phase(200, 45);
    set_worker_limits(1, 1);
    test_random_phase(200, 55);
    set_worker_limits(64, 64);
    test_random_phase(200, 50);
    set_worker_limits($urandom_range(1, 64), $urandom_range(1, 64));
    test_random_phase(200, 40);
    drain_results();

    $display("Covered %0d submits, %0d takes, %0d completions, %0d unused codes; %0d checked.",
             n_submit, n_take, n_complete, n_unused, n_checked);
    $display("Saw %0d full rejections, %0d empty takes, %0d idle completions, %0d scale-ups.",
             n_full, n_empty, n_no_active, n_scaled);
    if (errors == 0) begin
      $display("** priority_task_scheduler: PASSED **");
    end else begin
      $display("%0d mismatches", errors);
      $display("** priority_task_scheduler: FAILED **");
    end
    $finish;
  end

endmodule
